@@ rtl/static_link_stack_machine_assert.svh @@
// Assertion macros used by the checker file of the stack machine.
`ifndef STATIC_LINK_STACK_MACHINE_ASSERT_SVH
`define STATIC_LINK_STACK_MACHINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/slsm_pkg.sv @@
// Package: constants, types and helpers of the stack machine.
`timescale 1ns / 1ps
package slsm_pkg;
	localparam int STACK_DEPTH = 1024;
	localparam int CODE_DEPTH  = 4096;
	localparam int SAW         = $clog2(STACK_DEPTH);
	localparam int TW          = SAW + 1;
	localparam int PCW         = $clog2(CODE_DEPTH);
	localparam int WW          = 32;
	localparam int LEV_W       = 8;
	localparam int OPND_W      = 16;
	localparam int NPC_W       = 12;
	localparam int RESET_TOP   = 3;
	localparam int RESET_START = 1 % CODE_DEPTH;

	typedef enum logic [4:0] {
		OP_LOAD  = 5'd0,
		OP_LIT   = 5'd1,
		OP_STO   = 5'd2,
		OP_ADD   = 5'd3,
		OP_SUB   = 5'd4,
		OP_MUL   = 5'd5,
		OP_DIV   = 5'd6,
		OP_EQU   = 5'd7,
		OP_LSS   = 5'd8,
		OP_GTR   = 5'd9,
		OP_CALL  = 5'd10,
		OP_RET   = 5'd11,
		OP_RES   = 5'd12,
		OP_JMP   = 5'd13,
		OP_FJMP  = 5'd14,
		OP_HALT  = 5'd15,
		OP_NEG   = 5'd16,
		OP_READ  = 5'd17,
		OP_WRITE = 5'd18
	} opcode_t;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_HALT    = 3'd1,
		ST_DIV0    = 3'd2,
		ST_ILLEGAL = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_WALKD,
		S_EXEC,
		S_RD0,
		S_RD1,
		S_RD2,
		S_OP,
		S_DIV,
		S_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]               opcode;
		logic [LEV_W-1:0]         level;
		logic signed [OPND_W-1:0] operand;
		logic signed [WW-1:0]     read_value;
	} item_t;

	typedef struct packed {
		logic [NPC_W-1:0]     next_pc;
		logic                 write_valid;
		logic signed [WW-1:0] write_value;
		status_t              status;
	} result_t;

	typedef struct packed {
		logic           we;
		logic [SAW-1:0] waddr;
		logic [WW-1:0]  wdata;
		logic           re;
		logic [SAW-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic          start;
		logic [WW-1:0] a;
		logic [WW-1:0] b;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [WW-1:0] q;
	} div_rsp_t;

	function automatic logic [2:0] instr_len(input logic [4:0] op);
		logic [2:0] len;
		len = 3'd1;
		if (op == OP_LOAD || op == OP_STO || op == OP_READ || op == OP_CALL) begin
			len = 3'd4;
		end else if (op == OP_LIT || op == OP_RES || op == OP_JMP || op == OP_FJMP) begin
			len = 3'd3;
		end
		return len;
	endfunction
endpackage

@@ rtl/slsm_if.sv @@
// Channel interfaces: instruction items in, result items out.
`timescale 1ns / 1ps
interface slsm_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         opcode;
	logic [7:0]         level;
	logic signed [15:0] operand;
	logic signed [31:0] read_value;

	modport source(output valid, opcode, level, operand, read_value, input ready);
	modport sink(input valid, opcode, level, operand, read_value, output ready);
endinterface

interface slsm_out_if;
	logic               valid;
	logic               ready;
	logic [11:0]        next_pc;
	logic               write_valid;
	logic signed [31:0] write_value;
	logic [2:0]         status;

	modport source(output valid, next_pc, write_valid, write_value, status, input ready);
	modport sink(input valid, next_pc, write_valid, write_value, status, output ready);
endinterface

@@ rtl/slsm_stack_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module slsm_stack_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/slsm_div.sv @@
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module slsm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  slsm_pkg::div_req_t  req,
	output slsm_pkg::div_rsp_t  rsp
);
	localparam int CW = $clog2(slsm_pkg::WW) + 1;

	logic                    busy_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;
	logic                    neg_q;
	logic [slsm_pkg::WW-1:0] quo_q;
	logic [slsm_pkg::WW-1:0] mb_q;
	logic [slsm_pkg::WW:0]   rem_q;
	logic [slsm_pkg::WW:0]   shifted;
	logic [slsm_pkg::WW:0]   diff;
	logic                    na;
	logic                    nb;

	assign na      = req.a[slsm_pkg::WW-1];
	assign nb      = req.b[slsm_pkg::WW-1];
	assign shifted = {rem_q[slsm_pkg::WW-1:0], quo_q[slsm_pkg::WW-1]};
	assign diff    = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(slsm_pkg::WW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= na ? (0 - req.a) : req.a;
			mb_q  <= nb ? (0 - req.b) : req.b;
			rem_q <= '0;
			neg_q <= na ^ nb;
		end else if (busy_q) begin
			// restore when the trial subtract goes negative
			if (diff[slsm_pkg::WW]) begin
				rem_q <= shifted;
				quo_q <= {quo_q[slsm_pkg::WW-2:0], 1'b0};
			end else begin
				rem_q <= diff;
				quo_q <= {quo_q[slsm_pkg::WW-2:0], 1'b1};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = neg_q ? (0 - quo_q) : quo_q;
endmodule

@@ rtl/slsm_core.sv @@
// Sequencer and datapath: link walk, stack reads, operation, write-back, commit.
`timescale 1ns / 1ps
module slsm_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  slsm_pkg::item_t                    item,
	input  logic                               cfg_we,
	input  logic [slsm_pkg::NPC_W-1:0]         cfg_wdata,
	output slsm_pkg::ram_req_t                 ram_req,
	input  logic [slsm_pkg::WW-1:0]            ram_rdata,
	output slsm_pkg::div_req_t                 div_req,
	input  slsm_pkg::div_rsp_t                 div_rsp,
	input  logic                               slot_free,
	output logic                               res_valid,
	output slsm_pkg::result_t                  res
);
	localparam int SAW = slsm_pkg::SAW;
	localparam int TW  = slsm_pkg::TW;
	localparam int PCW = slsm_pkg::PCW;
	localparam int WW  = slsm_pkg::WW;
	localparam int VW  = WW + 2;
	localparam int RSW = ((TW > slsm_pkg::OPND_W) ? TW : slsm_pkg::OPND_W) + 2;

	slsm_pkg::state_t  state_q, state_d;
	slsm_pkg::status_t run_q, run_d;
	slsm_pkg::status_t st_q, st_d;
	slsm_pkg::opcode_t op_q, op_d;

	logic [SAW-1:0]            clr_q, clr_d;
	logic [PCW-1:0]            pc_q, pc_d;
	logic [SAW-1:0]            base_q, base_d;
	logic [TW-1:0]             top_q, top_d;
	logic [slsm_pkg::LEV_W-1:0] lev_q, lev_d;
	logic [1:0]                wcnt_q, wcnt_d;

	logic [slsm_pkg::OPND_W-1:0] opnd_q, opnd_d;
	logic [WW-1:0]   rv_q, rv_d;
	logic [WW-1:0]   link_q, link_d;
	logic [SAW-1:0]  ra0_q, ra0_d, ra1_q, ra1_d, wa_q, wa_d;
	logic [WW-1:0]   wd_q, wd_d, d0_q, d0_d, d1_q, d1_d;
	logic [TW-1:0]   ntop_q, ntop_d;
	logic [SAW-1:0]  nbase_q, nbase_d;
	logic [PCW-1:0]  np_q, np_d;
	logic            wv_q, wv_d;

	logic [PCW-1:0]        seq;
	logic [PCW-1:0]        tgt;
	logic signed [VW-1:0]  vsum;
	logic                  var_ok;
	logic [SAW-1:0]        vaddr;
	logic signed [RSW-1:0] rsum;
	logic                  res_ok;
	logic [WW-1:0]         sext;
	logic [WW-1:0]         prod;
	logic [WW-1:0]         call_data;
	logic                  a_lt_b;
	logic                  b_lt_a;

	assign seq    = pc_q + PCW'(slsm_pkg::instr_len(op_q));
	assign tgt    = opnd_q[PCW-1:0];
	assign sext   = WW'($signed(opnd_q));
	assign vsum   = $signed({2'b00, link_q}) + VW'($signed(opnd_q));
	assign var_ok = !vsum[VW-1] && (vsum < VW'(slsm_pkg::STACK_DEPTH));
	assign vaddr  = vsum[SAW-1:0];
	assign rsum   = $signed({{(RSW-TW){1'b0}}, top_q}) + RSW'($signed(opnd_q));
	assign res_ok = !rsum[RSW-1] && (rsum <= RSW'(slsm_pkg::STACK_DEPTH));
	assign prod   = d1_q * d0_q;
	assign a_lt_b = $signed(d1_q) < $signed(d0_q);
	assign b_lt_a = $signed(d0_q) < $signed(d1_q);

	always_comb begin
		unique case (wcnt_q)
			2'd0:    call_data = link_q;
			2'd1:    call_data = WW'(base_q);
			default: call_data = WW'(seq);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slsm_pkg::S_CLEAR;
			run_q   <= slsm_pkg::ST_RUN;
			clr_q   <= '0;
			pc_q    <= PCW'(slsm_pkg::RESET_START);
			base_q  <= '0;
			top_q   <= TW'(slsm_pkg::RESET_TOP);
			lev_q   <= '0;
			wcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			clr_q   <= clr_d;
			pc_q    <= pc_d;
			base_q  <= base_d;
			top_q   <= top_d;
			lev_q   <= lev_d;
			wcnt_q  <= wcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		st_q    <= st_d;
		opnd_q  <= opnd_d;
		rv_q    <= rv_d;
		link_q  <= link_d;
		ra0_q   <= ra0_d;
		ra1_q   <= ra1_d;
		wa_q    <= wa_d;
		wd_q    <= wd_d;
		d0_q    <= d0_d;
		d1_q    <= d1_d;
		ntop_q  <= ntop_d;
		nbase_q <= nbase_d;
		np_q    <= np_d;
		wv_q    <= wv_d;
	end

	always_comb begin
		state_d = state_q;
		run_d   = run_q;
		clr_d   = clr_q;
		pc_d    = pc_q;
		base_d  = base_q;
		top_d   = top_q;
		lev_d   = lev_q;
		wcnt_d  = wcnt_q;
		op_d    = op_q;
		st_d    = st_q;
		opnd_d  = opnd_q;
		rv_d    = rv_q;
		link_d  = link_q;
		ra0_d   = ra0_q;
		ra1_d   = ra1_q;
		wa_d    = wa_q;
		wd_d    = wd_q;
		d0_d    = d0_q;
		d1_d    = d1_q;
		ntop_d  = ntop_q;
		nbase_d = nbase_q;
		np_d    = np_q;
		wv_d    = wv_q;

		item_ready    = 1'b0;
		res_valid     = 1'b0;
		ram_req       = '0;
		div_req.start = 1'b0;
		div_req.a     = d1_q;
		div_req.b     = d0_q;

		unique case (state_q)
			slsm_pkg::S_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				clr_d         = clr_q + 1'b1;
				if (clr_q == SAW'(slsm_pkg::STACK_DEPTH - 1)) begin
					state_d = slsm_pkg::S_IDLE;
				end
			end
			slsm_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					op_d    = slsm_pkg::opcode_t'(item.opcode);
					opnd_d  = item.operand;
					rv_d    = item.read_value;
					link_d  = WW'(base_q);
					ntop_d  = top_q;
					nbase_d = base_q;
					wv_d    = 1'b0;
					wcnt_d  = '0;
					st_d    = slsm_pkg::ST_RUN;
					lev_d   = '0;
					if (item.opcode == slsm_pkg::OP_LOAD || item.opcode == slsm_pkg::OP_STO ||
						item.opcode == slsm_pkg::OP_READ || item.opcode == slsm_pkg::OP_CALL) begin
						lev_d = item.level;
					end
					if (run_q != slsm_pkg::ST_RUN) begin
						st_d    = run_q;
						state_d = slsm_pkg::S_DONE;
					end else begin
						state_d = slsm_pkg::S_WALK;
					end
				end
			end
			slsm_pkg::S_WALK: begin
				if (lev_q == '0) begin
					state_d = slsm_pkg::S_EXEC;
				end else if (link_q >= WW'(slsm_pkg::STACK_DEPTH)) begin
					st_d    = slsm_pkg::ST_RANGE;
					state_d = slsm_pkg::S_DONE;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = link_q[SAW-1:0];
					state_d       = slsm_pkg::S_WALKD;
				end
			end
			slsm_pkg::S_WALKD: begin
				link_d  = ram_rdata;
				lev_d   = lev_q - 1'b1;
				state_d = slsm_pkg::S_WALK;
			end
			slsm_pkg::S_EXEC: begin
				np_d    = seq;
				state_d = slsm_pkg::S_DONE;
				unique case (op_q)
					slsm_pkg::OP_LOAD: begin
						if (!var_ok || top_q >= TW'(slsm_pkg::STACK_DEPTH)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ra0_d   = vaddr;
							wa_d    = top_q[SAW-1:0];
							ntop_d  = top_q + 1'b1;
							state_d = slsm_pkg::S_RD0;
						end
					end
					slsm_pkg::OP_LIT: begin
						if (top_q >= TW'(slsm_pkg::STACK_DEPTH)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							wa_d    = top_q[SAW-1:0];
							wd_d    = sext;
							ntop_d  = top_q + 1'b1;
							state_d = slsm_pkg::S_WR;
						end
					end
					slsm_pkg::OP_STO: begin
						if (!var_ok || top_q == '0) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ra0_d   = SAW'(top_q - 1'b1);
							wa_d    = vaddr;
							ntop_d  = top_q - 1'b1;
							state_d = slsm_pkg::S_RD0;
						end
					end
					slsm_pkg::OP_ADD, slsm_pkg::OP_SUB, slsm_pkg::OP_MUL, slsm_pkg::OP_DIV,
					slsm_pkg::OP_EQU, slsm_pkg::OP_LSS, slsm_pkg::OP_GTR: begin
						if (top_q < TW'(2)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ra0_d   = SAW'(top_q - 1'b1);
							ra1_d   = SAW'(top_q - TW'(2));
							wa_d    = SAW'(top_q - TW'(2));
							ntop_d  = top_q - 1'b1;
							state_d = slsm_pkg::S_RD0;
						end
					end
					slsm_pkg::OP_CALL: begin
						if (({1'b0, top_q} + (TW+1)'(3)) > (TW+1)'(slsm_pkg::STACK_DEPTH)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							nbase_d = top_q[SAW-1:0];
							ntop_d  = top_q + TW'(3);
							np_d    = tgt;
							state_d = slsm_pkg::S_WR;
						end
					end
					slsm_pkg::OP_RET: begin
						if (({1'b0, base_q} + TW'(2)) >= TW'(slsm_pkg::STACK_DEPTH)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ra0_d   = base_q + 1'b1;
							ra1_d   = base_q + SAW'(2);
							ntop_d  = TW'(base_q);
							state_d = slsm_pkg::S_RD0;
						end
					end
					slsm_pkg::OP_RES: begin
						if (!res_ok) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ntop_d = rsum[TW-1:0];
						end
					end
					slsm_pkg::OP_JMP: begin
						np_d = tgt;
					end
					slsm_pkg::OP_FJMP, slsm_pkg::OP_NEG, slsm_pkg::OP_WRITE: begin
						if (top_q == '0) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							ra0_d = SAW'(top_q - 1'b1);
							wa_d  = SAW'(top_q - 1'b1);
							if (op_q != slsm_pkg::OP_NEG) begin
								ntop_d = top_q - 1'b1;
							end
							state_d = slsm_pkg::S_RD0;
						end
					end
					slsm_pkg::OP_HALT: begin
						st_d = slsm_pkg::ST_HALT;
					end
					slsm_pkg::OP_READ: begin
						if (!var_ok) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							wa_d    = vaddr;
							wd_d    = rv_q;
							state_d = slsm_pkg::S_WR;
						end
					end
					default: begin
						st_d = slsm_pkg::ST_ILLEGAL;
					end
				endcase
			end
			slsm_pkg::S_RD0: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ra0_q;
				state_d       = slsm_pkg::S_RD1;
			end
			slsm_pkg::S_RD1: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ra1_q;
				d0_d          = ram_rdata;
				state_d       = slsm_pkg::S_RD2;
			end
			slsm_pkg::S_RD2: begin
				d1_d    = ram_rdata;
				state_d = slsm_pkg::S_OP;
			end
			slsm_pkg::S_OP: begin
				state_d = slsm_pkg::S_WR;
				unique case (op_q)
					slsm_pkg::OP_LOAD, slsm_pkg::OP_STO: wd_d = d0_q;
					slsm_pkg::OP_ADD: wd_d = d1_q + d0_q;
					slsm_pkg::OP_SUB: wd_d = d1_q - d0_q;
					slsm_pkg::OP_MUL: wd_d = prod;
					slsm_pkg::OP_EQU: wd_d = WW'(d1_q == d0_q);
					slsm_pkg::OP_LSS: wd_d = WW'(a_lt_b);
					slsm_pkg::OP_GTR: wd_d = WW'(b_lt_a);
					slsm_pkg::OP_NEG: wd_d = 0 - d0_q;
					slsm_pkg::OP_DIV: begin
						if (d0_q == '0) begin
							st_d    = slsm_pkg::ST_DIV0;
							state_d = slsm_pkg::S_DONE;
						end else begin
							div_req.start = 1'b1;
							state_d       = slsm_pkg::S_DIV;
						end
					end
					slsm_pkg::OP_RET: begin
						state_d = slsm_pkg::S_DONE;
						if (d0_q >= WW'(slsm_pkg::STACK_DEPTH)) begin
							st_d = slsm_pkg::ST_RANGE;
						end else begin
							nbase_d = d0_q[SAW-1:0];
							np_d    = d1_q[PCW-1:0];
						end
					end
					slsm_pkg::OP_FJMP: begin
						state_d = slsm_pkg::S_DONE;
						if (d0_q == '0) begin
							np_d = tgt;
						end
					end
					slsm_pkg::OP_WRITE: begin
						state_d = slsm_pkg::S_DONE;
						wv_d    = 1'b1;
						wd_d    = d0_q;
					end
					default: begin
						state_d = slsm_pkg::S_DONE;
					end
				endcase
			end
			slsm_pkg::S_DIV: begin
				if (div_rsp.done) begin
					wd_d    = div_rsp.q;
					state_d = slsm_pkg::S_WR;
				end
			end
			slsm_pkg::S_WR: begin
				ram_req.we = 1'b1;
				if (op_q == slsm_pkg::OP_CALL) begin
					// frame: static link, old base, return address
					ram_req.waddr = top_q[SAW-1:0] + SAW'(wcnt_q);
					ram_req.wdata = call_data;
					wcnt_d        = wcnt_q + 1'b1;
					if (wcnt_q == 2'd2) begin
						state_d = slsm_pkg::S_DONE;
					end
				end else begin
					ram_req.waddr = wa_q;
					ram_req.wdata = wd_q;
					state_d       = slsm_pkg::S_DONE;
				end
			end
			slsm_pkg::S_DONE: begin
				if (slot_free) begin
					res_valid = 1'b1;
					state_d   = slsm_pkg::S_IDLE;
					if (st_q == slsm_pkg::ST_RUN) begin
						top_d  = ntop_q;
						base_d = nbase_q;
						pc_d   = np_q;
					end else begin
						run_d = st_q;
					end
				end
			end
			default: begin
				state_d = slsm_pkg::S_IDLE;
			end
		endcase

		// restart: stack contents are kept
		if (cfg_we) begin
			pc_d   = cfg_wdata[PCW-1:0];
			base_d = '0;
			top_d  = TW'(slsm_pkg::RESET_TOP);
			run_d  = slsm_pkg::ST_RUN;
		end
	end

	assign res.next_pc     = slsm_pkg::NPC_W'((st_q == slsm_pkg::ST_RUN) ? np_q : pc_q);
	assign res.write_valid = (st_q == slsm_pkg::ST_RUN) && wv_q;
	assign res.write_value = ((st_q == slsm_pkg::ST_RUN) && wv_q) ? wd_q : '0;
	assign res.status      = st_q;
endmodule

@@ rtl/static_link_stack_machine.sv @@
// Top level of the stack machine: core, stack memory, divider, result register.
// Use:
//   cmd carries one decoded instruction per item (opcode, level, operand,
//   read_value); rsp returns one item per instruction (next_pc, write_valid,
//   write_value, status). Both channels move an item when valid and ready
//   are high at a rising clk edge.
//   cfg_we/cfg_wdata set the start address and restart the machine
//   (pc, base, top and run state); the stack contents are kept.
// Sequencing:
//   One instruction at a time: the next item is taken only after the
//   result of the last one has been passed to the output register. A
//   call writes its frame of three words, each static link level walked
//   adds a stack read, a divide waits for the serial divider, and a
//   stopped machine answers without executing the instruction.
// Reset:
//   arst_n sets control state to its reset values and starts a pass that
//   zeroes all 1024 stack words; cmd.ready stays low until it ends.
// Stall:
//   A result waits in the output register while rsp.ready is low; the
//   next instruction may be taken and runs up to its result, then holds.
`timescale 1ns / 1ps
module static_link_stack_machine (
	input  logic                         clk,
	input  logic                         arst_n,
	slsm_in_if.sink                      cmd,
	slsm_out_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [slsm_pkg::NPC_W-1:0]   cfg_wdata
);
	slsm_pkg::item_t    item;
	slsm_pkg::ram_req_t ram_req;
	slsm_pkg::div_req_t div_req;
	slsm_pkg::div_rsp_t div_rsp;
	slsm_pkg::result_t  res;
	slsm_pkg::result_t  res_q;
	logic [slsm_pkg::WW-1:0] ram_rdata;
	logic res_valid;
	logic out_valid_q;
	logic slot_free;

	assign item.opcode     = cmd.opcode;
	assign item.level      = cmd.level;
	assign item.operand    = cmd.operand;
	assign item.read_value = cmd.read_value;
	assign slot_free       = !out_valid_q || rsp.ready;

	slsm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd.valid),
		.item_ready (cmd.ready),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.slot_free  (slot_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	slsm_stack_ram #(
		.DEPTH (slsm_pkg::STACK_DEPTH),
		.WIDTH (slsm_pkg::WW)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	slsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.next_pc     = res_q.next_pc;
	assign rsp.write_valid = res_q.write_valid;
	assign rsp.write_value = res_q.write_value;
	assign rsp.status      = res_q.status;
endmodule

@@ rtl/slsm_checker.sv @@
// Port-level checks of the stack machine, bound to the top level.
`timescale 1ns / 1ps
`include "static_link_stack_machine_assert.svh"
module slsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [11:0] rsp_next_pc,
	input logic        rsp_write_valid,
	input logic [31:0] rsp_write_value,
	input logic [2:0]  rsp_status
);
	`SLSM_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
	`SLSM_ASSERT_NOW(a_write_running, rsp_valid && rsp_write_valid, rsp_status == 3'd0, "write on stop")
	`SLSM_ASSERT_NOW(a_no_stray_value, rsp_valid && !rsp_write_valid, rsp_write_value == 32'd0,
		"stray write value")
	`SLSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_pc),
		"result dropped under stall")
endmodule

bind static_link_stack_machine slsm_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_next_pc     (rsp.next_pc),
	.rsp_write_valid (rsp.write_valid),
	.rsp_write_value (rsp.write_value),
	.rsp_status      (rsp.status)
);
